// ----- sv/bmie_pkg.sv -----
// shared types, codes and constants of the byte machine instruction executor
package bmie_pkg;

  localparam int unsigned MemDepth  = 256;
  localparam int unsigned RegCount  = 16;
  localparam int unsigned MemAw     = $clog2(MemDepth);
  localparam int unsigned RegAw     = $clog2(RegCount);
  localparam int unsigned IdxW      = 9;
  localparam int unsigned InW       = 16;
  localparam int unsigned OutW      = 24;
  localparam int unsigned CfgW      = 9;

  // configuration register indexes
  localparam logic CFG_COPY_START = 1'b0;
  localparam logic CFG_PROG_LEN   = 1'b1;

  // fixed register numbers used by store-to-zero and the jumps
  localparam logic [RegAw-1:0] REG_R0 = RegAw'(0);
  localparam logic [RegAw-1:0] REG_R1 = RegAw'(1);

  // mini-float fields and saturation codes
  localparam logic [7:0] MF_SIGN    = 8'h80;
  localparam logic [7:0] MF_EXP     = 8'h70;
  localparam logic [7:0] MF_FRAC    = 8'h0F;
  localparam logic [7:0] MF_NEG_MAX = 8'hFF;
  localparam logic [7:0] MF_POS_MAX = 8'h7F;
  localparam logic [7:0] MF_ZERO    = 8'h00;

  typedef enum logic [3:0] {
    OP_LOAD_MEM = 4'h1,
    OP_LOAD_IMM = 4'h2,
    OP_STORE    = 4'h3,
    OP_MOVE     = 4'h4,
    OP_ADD      = 4'h5,
    OP_FADD     = 4'h6,
    OP_OR       = 4'h7,
    OP_AND      = 4'h8,
    OP_XOR      = 4'h9,
    OP_ROTR     = 4'hA,
    OP_JEQ      = 4'hB,
    OP_HALT     = 4'hC,
    OP_JGT      = 4'hD
  } op_e;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [7:0]       data;
  } dm_wr_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
  } dm_rd_t;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [7:0]       data;
  } rf_wr_t;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr_a;
    logic [RegAw-1:0] addr_b;
  } rf_rd_t;

endpackage

// ----- sv/bmie_dmem.sv -----
// 256-byte data memory with per-entry valid bits and a registered read port
module bmie_dmem import bmie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dm_wr_t     wr_i,
  input  dm_rd_t     rd_i,
  output logic [7:0] rdata_o
);

  logic [7:0]          mem [MemDepth];
  logic [MemDepth-1:0] vld_q;
  logic [7:0]          rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvld_q <= vld_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 8'h00;

endmodule

// ----- sv/bmie_rf.sv -----
// sixteen 8-bit registers, two registered read ports and one write port
module bmie_rf import bmie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rf_wr_t     wr_i,
  input  rf_rd_t     rd_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o
);

  logic [7:0]          regs [RegCount];
  logic [RegCount-1:0] vld_q;
  logic [7:0]          rda_q, rdb_q;
  logic                rva_q, rvb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      regs[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rda_q <= regs[rd_i.addr_a];
      rdb_q <= regs[rd_i.addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rva_q <= 1'b0;
      rvb_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rva_q <= vld_q[rd_i.addr_a];
        rvb_q <= vld_q[rd_i.addr_b];
      end
    end
  end

  assign rdata_a_o = rva_q ? rda_q : 8'h00;
  assign rdata_b_o = rvb_q ? rdb_q : 8'h00;

endmodule

// ----- sv/byte_machine_instruction_executor.sv -----
// top level: instruction buffer, three-phase sequencer, register file and data memory
//
// Each accepted word is one 16-bit instruction. The executor copies its two bytes into the
// data memory at copy_start plus a wrapping offset, then runs it against sixteen 8-bit
// registers and writes one result word. An instruction passes through three sequencer phases
// (high copy byte, low copy byte, execute), set by the single write port of the data
// memory, which takes both copy bytes and any store; the execute phase waits while the
// output register is full. A one-word input buffer takes the next instruction while
// the current one executes, and the output register holds a finished result while the next
// instruction proceeds. Memory and registers read as zero after reset through valid bits,
// so no clearing pass is needed. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
module byte_machine_instruction_executor import bmie_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // [15:0] instr_word
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [8:0] next_index, [9] halted, [10] print_valid, [18:11] print_byte, [19] unknown_op
  output logic [OutW-1:0] m_axis_tdata,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COPY_HI = 2'd1;
  localparam logic [1:0] ST_COPY_LO = 2'd2;
  localparam logic [1:0] ST_EXEC    = 2'd3;

  function automatic logic signed [13:0] mf_decode(logic [7:0] b);
    logic [11:0] mag;
    mag = 12'({1'b1, b[3:0]}) << b[6:4];
    return b[7] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

  function automatic logic [7:0] mf_encode(logic signed [13:0] v);
    logic        sign;
    logic [12:0] mag;
    logic [3:0]  p;
    logic [2:0]  ex;
    logic [12:0] sh;
    logic [7:0]  enc;
    sign = v[13];
    mag  = sign ? 13'(-v) : v[12:0];
    p    = '0;
    for (int i = 0; i < 13; i++) begin
      if (mag[i]) p = 4'(i);
    end
    ex = 3'(p - 4'd4);
    sh = mag >> ex;
    if (mag == '0 || p < 4'd4) begin
      enc = MF_ZERO;
    end else if (p > 4'd11) begin
      enc = sign ? MF_NEG_MAX : MF_POS_MAX;
    end else begin
      enc = (sign ? MF_SIGN : 8'h00) | ({1'b0, ex, 4'h0} & MF_EXP) | ({4'h0, sh[3:0]} & MF_FRAC);
    end
    return enc;
  endfunction

  // configuration and architectural pointers
  logic [MemAw-1:0] copy_start_q, copy_off_q;
  logic [IdxW-1:0]  prog_len_q, instr_idx_q;

  // input buffer and current instruction
  logic            ibuf_vld_q;
  logic [InW-1:0]  ibuf_q, cur_q;
  logic [1:0]      st_q, st_d;
  logic            out_free, exec_done, start;

  // per-instruction results captured in the low-copy phase
  logic [7:0]         res_q, res_d;
  logic signed [13:0] fsum_q, fsum_d;
  logic               fadd_q, fadd_d;
  logic               rwr_q, rwr_d;
  logic [RegAw-1:0]   rwa_q, rwa_d;
  logic               store_q, store_d;
  logic               pv_q, pv_d;
  logic [7:0]         pb_q, pb_d;
  logic               unk_q, unk_d;
  logic [IdxW-1:0]    next_q, next_d;

  // output register
  logic            out_vld_q;
  logic [IdxW-1:0] o_next_q;
  logic            o_halt_q, o_pv_q, o_unk_q;
  logic [7:0]      o_pb_q;

  op_e              op;
  logic [RegAw-1:0] f_r, f_x, f_y;
  logic [7:0]       xy, hi_b, lo_b, dm_rdata, ra, rb;
  logic [MemAw-1:0] base, base1;
  logic [15:0]      rot;
  dm_wr_t           dm_wr;
  dm_rd_t           dm_rd;
  rf_wr_t           rf_wr;
  rf_rd_t           rf_rd;

  assign op    = op_e'(cur_q[15:12]);
  assign f_r   = cur_q[11:8];
  assign f_x   = cur_q[7:4];
  assign f_y   = cur_q[3:0];
  assign xy    = cur_q[7:0];
  assign hi_b  = cur_q[15:8];
  assign lo_b  = cur_q[7:0];
  assign base  = copy_start_q + copy_off_q;
  assign base1 = base + MemAw'(1);

  assign out_free      = !out_vld_q || m_axis_tready;
  assign exec_done     = (st_q == ST_EXEC) && out_free;
  assign start         = ibuf_vld_q && ((st_q == ST_IDLE) || exec_done);
  assign s_axis_tready = !ibuf_vld_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (start) st_d = ST_COPY_HI;
      ST_COPY_HI: st_d = ST_COPY_LO;
      ST_COPY_LO: st_d = ST_EXEC;
      ST_EXEC: begin
        if (exec_done) st_d = start ? ST_COPY_HI : ST_IDLE;
      end
      default:    st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      ibuf_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      copy_start_q <= '0;
      prog_len_q   <= '0;
      copy_off_q   <= '0;
      instr_idx_q  <= '0;
    end else begin
      st_q <= st_d;
      if (s_axis_tvalid && s_axis_tready) begin
        ibuf_vld_q <= 1'b1;
      end else if (start) begin
        ibuf_vld_q <= 1'b0;
      end
      if (exec_done) begin
        out_vld_q   <= 1'b1;
        instr_idx_q <= next_q;
        copy_off_q  <= copy_off_q + MemAw'(2);
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COPY_START: copy_start_q <= cfg_data_i[MemAw-1:0];
          CFG_PROG_LEN:   prog_len_q   <= cfg_data_i;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) ibuf_q <= s_axis_tdata;
    if (start) cur_q <= ibuf_q;
    if (st_q == ST_COPY_LO) begin
      res_q   <= res_d;
      fsum_q  <= fsum_d;
      fadd_q  <= fadd_d;
      rwr_q   <= rwr_d;
      rwa_q   <= rwa_d;
      store_q <= store_d;
      pv_q    <= pv_d;
      pb_q    <= pb_d;
      unk_q   <= unk_d;
      next_q  <= next_d;
    end
    if (exec_done) begin
      o_next_q <= next_q;
      o_halt_q <= (next_q >= prog_len_q);
      o_pv_q   <= pv_q;
      o_pb_q   <= pb_q;
      o_unk_q  <= unk_q;
    end
  end

  // register reads in the high-copy phase
  always_comb begin
    rf_rd.en     = (st_q == ST_COPY_HI);
    rf_rd.addr_a = f_r;
    rf_rd.addr_b = REG_R0;
    case (op) inside
      OP_MOVE, OP_ADD, OP_FADD, OP_OR, OP_AND, OP_XOR: rf_rd.addr_a = f_x;
      OP_STORE: if (xy == 8'h00) rf_rd.addr_a = REG_R1;
      default: ;
    endcase
    case (op) inside
      OP_ADD, OP_FADD, OP_OR, OP_AND, OP_XOR: rf_rd.addr_b = f_y;
      default: ;
    endcase
  end

  // data memory port: two copy bytes, then the store
  always_comb begin
    dm_rd.en   = (st_q == ST_COPY_HI);
    dm_rd.addr = xy;
    dm_wr.en   = 1'b0;
    dm_wr.addr = base;
    dm_wr.data = hi_b;
    unique case (st_q)
      ST_COPY_HI: dm_wr.en = 1'b1;
      ST_COPY_LO: begin
        dm_wr.en   = 1'b1;
        dm_wr.addr = base1;
        dm_wr.data = lo_b;
      end
      ST_EXEC: begin
        dm_wr.en   = exec_done && store_q;
        dm_wr.addr = xy;
        dm_wr.data = res_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    rf_wr.en   = exec_done && rwr_q;
    rf_wr.addr = rwa_q;
    rf_wr.data = fadd_q ? mf_encode(fsum_q) : res_q;
  end

  assign rot = {ra, ra} >> xy[2:0];

  // operate in the low-copy phase
  always_comb begin
    res_d   = ra;
    fsum_d  = mf_decode(ra) + mf_decode(rb);
    fadd_d  = 1'b0;
    rwr_d   = 1'b0;
    rwa_d   = f_r;
    store_d = 1'b0;
    pv_d    = 1'b0;
    pb_d    = 8'h00;
    unk_d   = 1'b0;
    next_d  = instr_idx_q + IdxW'(1);
    case (op)
      OP_LOAD_MEM: begin
        rwr_d = 1'b1;
        // copy bytes written this instruction are not yet visible to the read
        if (xy == base)       res_d = hi_b;
        else if (xy == base1) res_d = lo_b;
        else                  res_d = dm_rdata;
      end
      OP_LOAD_IMM: begin
        rwr_d = 1'b1;
        res_d = xy;
      end
      OP_STORE: begin
        store_d = 1'b1;
        if (xy == 8'h00) begin
          pv_d = 1'b1;
          pb_d = ra;
        end
      end
      OP_MOVE: begin
        rwr_d = 1'b1;
        rwa_d = f_y;
      end
      OP_ADD: begin
        rwr_d = 1'b1;
        res_d = ra + rb;
      end
      OP_FADD: begin
        rwr_d  = 1'b1;
        fadd_d = 1'b1;
      end
      OP_OR: begin
        rwr_d = 1'b1;
        res_d = ra | rb;
      end
      OP_AND: begin
        rwr_d = 1'b1;
        res_d = ra & rb;
      end
      OP_XOR: begin
        rwr_d = 1'b1;
        res_d = ra ^ rb;
      end
      OP_ROTR: begin
        rwr_d = 1'b1;
        res_d = rot[7:0];
      end
      OP_JEQ:  if (ra == rb) next_d = IdxW'(xy);
      OP_HALT: next_d = prog_len_q;
      OP_JGT:  if ($signed(ra) > $signed(rb)) next_d = IdxW'(xy);
      default: unk_d = 1'b1;
    endcase
  end

  bmie_rf u_rf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rf_wr),
    .rd_i      (rf_rd),
    .rdata_a_o (ra),
    .rdata_b_o (rb)
  );

  bmie_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dm_wr),
    .rd_i    (dm_rd),
    .rdata_o (dm_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'h0, o_unk_q, o_pb_q, o_pv_q, o_halt_q, o_next_q};

  a_phase_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_COPY_HI |=> st_q == ST_COPY_LO)
    else $error("high copy phase not followed by low copy phase");

  a_phase_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_COPY_LO |=> st_q == ST_EXEC)
    else $error("low copy phase not followed by execute");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> m_axis_tvalid)
    else $error("executed instruction gave no result word");

  a_off_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_off_q[0] == 1'b0)
    else $error("copy offset lost its alignment");

  a_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !o_pv_q |-> o_pb_q == 8'h00)
    else $error("print byte set without a print");

endmodule
